// ===== rtl/core/hwfd_pkg.sv =====
// Shared types and constants for the stereo widener with fractional delay.
// No dependencies; imported by hwfd_smul and the top level.
package hwfd_pkg;

   localparam int unsigned RING_DEPTH  = 512;
   localparam int unsigned SAMPLE_BITS = 16;
   localparam int unsigned ADDR_W      = $clog2(RING_DEPTH);
   localparam int unsigned FILL_W      = $clog2(RING_DEPTH + 1);

   localparam int unsigned DELAY_W = 18;
   localparam int unsigned MIX_W   = 17;
   localparam int unsigned FRAC_W  = 8;
   localparam int unsigned POS_W   = ADDR_W + FRAC_W + 1;

   localparam int unsigned ENTRY_W = SAMPLE_BITS + 1;
   localparam int unsigned DIFF_W  = ENTRY_W + 1;
   localparam int unsigned PROD_W  = DIFF_W + FRAC_W + 1;
   localparam int unsigned D_W     = ENTRY_W + FRAC_W + 1;
   localparam int unsigned X_W     = D_W + 1;
   localparam int unsigned ACC_W   = X_W + MIX_W;
   localparam int unsigned Y_W     = ACC_W + 1;
   localparam int unsigned SHIFT_Q = 24;
   localparam int unsigned Q_W     = Y_W - SHIFT_Q;
   localparam int unsigned STEPS   = MIX_W - 1;
   localparam int unsigned CNT_W   = $clog2(STEPS);

   localparam logic [DELAY_W-1:0] DELAY_MIN = DELAY_W'(512);
   localparam logic [DELAY_W-1:0] DELAY_MAX = DELAY_W'(RING_DEPTH * 256);
   localparam logic [MIX_W-1:0]   MIX_ONE   = MIX_W'(65536);

   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(61440);
   localparam logic [MIX_W-1:0]   MIX_RESET   = MIX_W'(32768);

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = DELAY_W;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX   = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_INTERP,
      S_MUL,
      S_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } smul_ctl_type;

endpackage

// ===== rtl/core/hwfd_smul.sv =====
// Bit-serial multiplier, two lanes sharing one mix multiplier word.
// Depends on hwfd_pkg.
module hwfd_smul (
   input  logic                                 clock,
   input  hwfd_pkg::smul_ctl_type               ctl,
   input  logic [hwfd_pkg::MIX_W-1:0]           mix,
   input  logic signed [hwfd_pkg::X_W-1:0]      x_left,
   input  logic signed [hwfd_pkg::X_W-1:0]      x_right,
   output logic signed [hwfd_pkg::ACC_W-1:0]    acc_left,
   output logic signed [hwfd_pkg::ACC_W-1:0]    acc_right
);
   import hwfd_pkg::*;

   logic [STEPS-1:0]        m_sh_ff, m_sh_in;
   logic signed [ACC_W-1:0] xl_ff, xl_in, xr_ff, xr_in;
   logic signed [ACC_W-1:0] accl_ff, accl_in, accr_ff, accr_in;
   logic signed [ACC_W-1:0] xl_ext, xr_ext;

   assign xl_ext = ACC_W'(x_left);
   assign xr_ext = ACC_W'(x_right);

   // MSB first: double the partial sum, add the operand when the mix bit is set
   always_comb begin
      m_sh_in = m_sh_ff;
      xl_in   = xl_ff;
      xr_in   = xr_ff;
      accl_in = accl_ff;
      accr_in = accr_ff;
      if (ctl.load) begin
         m_sh_in = mix[STEPS-1:0];
         xl_in   = xl_ext;
         xr_in   = xr_ext;
         accl_in = mix[MIX_W-1] ? xl_ext : '0;
         accr_in = mix[MIX_W-1] ? xr_ext : '0;
      end else if (ctl.step) begin
         m_sh_in = {m_sh_ff[STEPS-2:0], 1'b0};
         accl_in = {accl_ff[ACC_W-2:0], 1'b0} + (m_sh_ff[STEPS-1] ? xl_ff : '0);
         accr_in = {accr_ff[ACC_W-2:0], 1'b0} + (m_sh_ff[STEPS-1] ? xr_ff : '0);
      end
   end

   always_ff @(posedge clock) begin
      m_sh_ff <= m_sh_in;
      xl_ff   <= xl_in;
      xr_ff   <= xr_in;
      accl_ff <= accl_in;
      accr_ff <= accr_in;
   end

   assign acc_left  = accl_ff;
   assign acc_right = accr_ff;

endmodule

// ===== rtl/core/haas_widener_fractional_delay.sv =====
// Top level of the stereo widener: sum ring, fractional read, serial mixing.
// Depends on hwfd_pkg and hwfd_smul.
//
//  Channel | Direction | Transaction contents
//  --------+-----------+----------------------------------------------------
//  req_    | in        | one stereo pair: in_left, in_right
//  rsp_    | out       | one stereo pair: out_left, out_right
//  csr_    | in        | register write: 0 = delay_q8, 1 = mix_q16
//
// Each item runs these steps before the next request is accepted: the two ring
// neighbors are fetched one after the other, the new sum is interpolated and written,
// 16 bit-serial multiplier steps run over the mix bits, and S_OUT rounds the output.
// The result sits in an output register, so a stalled rsp_ side does not hold up
// the next request until a second result is ready. Synchronous reset clears control
// state at once; the ring needs no clearing pass because a fill count marks entries
// never written, and those read as zero.
module haas_widener_fractional_delay (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [2*hwfd_pkg::SAMPLE_BITS-1:0]    req_tdata,   // in_left, in_right
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [2*hwfd_pkg::SAMPLE_BITS-1:0]    rsp_tdata,   // out_left, out_right
   input  logic                                  csr_wen,
   input  logic [hwfd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hwfd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import hwfd_pkg::*;

   // round to nearest (ties up) from Q24 and saturate to the sample range
   function automatic logic [SAMPLE_BITS-1:0] round_sat(
      input logic signed [SAMPLE_BITS-1:0] smp,
      input logic signed [ACC_W-1:0]       acc
   );
      logic signed [Y_W-1:0] y;
      logic signed [Q_W-1:0] q;
      logic [SAMPLE_BITS-1:0] res;
      y = (Y_W'(smp) <<< SHIFT_Q) - Y_W'(acc) + (Y_W'(1) <<< (SHIFT_Q - 1));
      q = y[Y_W-1:SHIFT_Q];
      if (q[Q_W-1:SAMPLE_BITS-1] == '0 || q[Q_W-1:SAMPLE_BITS-1] == '1) begin
         res = q[SAMPLE_BITS-1:0];
      end else if (q[Q_W-1]) begin
         res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return res;
   endfunction

   // control state
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   head_ff, head_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic [MIX_W-1:0]    mix_ff, mix_in;

   // payload
   logic signed [SAMPLE_BITS-1:0] inl_ff, inl_in, inr_ff, inr_in;
   logic [ADDR_W-1:0]   ib_ff, ib_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   logic                va_ff, va_in, vb_ff, vb_in;
   logic signed [ENTRY_W-1:0] a_ff, a_in;
   logic [MIX_W-1:0]    m_ff, m_in;
   logic [2*SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   // ring memory
   logic [ENTRY_W-1:0]  ring_mem [RING_DEPTH];
   logic [ENTRY_W-1:0]  rdata_ff;
   logic [ADDR_W-1:0]   mem_raddr;
   logic                mem_we;
   logic [ENTRY_W-1:0]  mem_wdata;

   // address generation
   logic [DELAY_W-1:0]  delay_cl;
   logic [MIX_W-1:0]    mix_cl;
   logic [POS_W-1:0]    pos;
   logic [ADDR_W:0]     ip_raw;
   logic [ADDR_W-1:0]   ia, ib;

   // interpolation
   logic signed [ENTRY_W-1:0] b_val;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [PROD_W-1:0]  prod;
   logic signed [D_W-1:0]     interp;
   logic signed [X_W-1:0]     x_left, x_right;
   logic signed [ACC_W-1:0]   acc_left, acc_right;
   smul_ctl_type              smul_ctl;

   logic req_acc, out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // clamp the registers into their meaningful ranges
   assign delay_cl = (delay_ff < DELAY_MIN) ? DELAY_MIN :
                     (delay_ff > DELAY_MAX) ? DELAY_MAX : delay_ff;
   assign mix_cl   = (mix_ff > MIX_ONE) ? MIX_ONE : mix_ff;

   // read position, Q8, always within one ring length ahead of the head
   assign pos    = POS_W'({head_ff, {FRAC_W{1'b0}}}) + POS_W'(DELAY_MAX) - POS_W'(delay_cl);
   assign ip_raw = pos[POS_W-1:FRAC_W];
   assign ia     = (ip_raw >= (ADDR_W+1)'(RING_DEPTH)) ?
                   ADDR_W'(ip_raw - (ADDR_W+1)'(RING_DEPTH)) : ip_raw[ADDR_W-1:0];
   assign ib     = (ia == ADDR_W'(RING_DEPTH - 1)) ? '0 : ia + 1'b1;

   // fetch the lower neighbor on acceptance, the upper one in the next cycle
   assign mem_raddr = (state_ff == S_IDLE) ? ia : ib_ff;
   assign mem_we    = (state_ff == S_INTERP);
   assign mem_wdata = ENTRY_W'(inl_ff) + ENTRY_W'(inr_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[head_ff] <= mem_wdata;
      end
      rdata_ff <= ring_mem[mem_raddr];
   end

   // d = a*256 + (b - a)*f, exact
   assign b_val   = vb_ff ? $signed(rdata_ff) : '0;
   assign diff    = DIFF_W'(b_val) - DIFF_W'(a_ff);
   assign prod    = diff * $signed({1'b0, frac_ff});
   assign interp  = (D_W'(a_ff) <<< FRAC_W) + D_W'(prod);
   // y = in*2^24 - mix*(256*in +/- d)
   assign x_left  = (X_W'(inl_ff) <<< FRAC_W) + X_W'(interp);
   assign x_right = (X_W'(inr_ff) <<< FRAC_W) - X_W'(interp);

   assign smul_ctl.load = (state_ff == S_INTERP);
   assign smul_ctl.step = (state_ff == S_MUL);

   hwfd_smul u_smul (
      .clock     (clock),
      .ctl       (smul_ctl),
      .mix       (m_ff),
      .x_left    (x_left),
      .x_right   (x_right),
      .acc_left  (acc_left),
      .acc_right (acc_right)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      delay_in     = delay_ff;
      mix_in       = mix_ff;
      inl_in       = inl_ff;
      inr_in       = inr_ff;
      ib_in        = ib_ff;
      frac_in      = frac_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      a_in         = a_ff;
      m_in         = m_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the held result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wen) begin
         case (csr_index)
            CSR_DELAY: delay_in = csr_wdata[DELAY_W-1:0];
            CSR_MIX:   mix_in   = csr_wdata[MIX_W-1:0];
            default:   ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               inl_in   = $signed(req_tdata[SAMPLE_BITS-1:0]);
               inr_in   = $signed(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
               ib_in    = ib;
               frac_in  = pos[FRAC_W-1:0];
               // entries at or above the fill count were never written
               va_in    = (FILL_W'(ia) < fill_ff);
               vb_in    = (FILL_W'(ib) < fill_ff);
               m_in     = mix_cl;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            a_in     = va_ff ? $signed(rdata_ff) : '0;
            state_in = S_INTERP;
         end
         S_INTERP: begin
            // write the new sum after both reads, then advance the head
            head_in  = (head_ff == ADDR_W'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            if (fill_ff != FILL_W'(RING_DEPTH)) begin
               fill_in = fill_ff + 1'b1;
            end
            cnt_in   = CNT_W'(STEPS - 1);
            state_in = S_MUL;
         end
         S_MUL: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_data_in  = {round_sat(inr_ff, acc_right), round_sat(inl_ff, acc_left)};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         delay_ff     <= DELAY_RESET;
         mix_ff       <= MIX_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         delay_ff     <= delay_in;
         mix_ff       <= mix_in;
      end
   end

   always_ff @(posedge clock) begin
      inl_ff      <= inl_in;
      inr_ff      <= inr_in;
      ib_ff       <= ib_in;
      frac_ff     <= frac_in;
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      a_ff        <= a_in;
      m_ff        <= m_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
